// ===== design/pvm_pkg.sv =====
// ----------------------------------------------------------------------------
// pvm_pkg: shared types and constants of the PCM voice mixer
// Action codes, field types and the arithmetic sizes of the shared datapath.
// ----------------------------------------------------------------------------
package pvm_pkg;

   // Default configuration of the mixer.
   localparam int EFFECT_VOICES_DEF = 8;
   localparam int SAMPLE_WORDS_DEF  = 65536;

   // A frame address is base + 2*pos + 1 at most, which needs 18 bits.
   localparam int FULL_ADDR_W  = 18;
   // Reciprocal scaling used to reduce an address modulo the memory depth.
   localparam int RECIP_SHIFT  = 18;
   localparam int QUOT_W       = 9;

   // Operand and product widths of the shared signed multiplier.
   localparam int MUL_A_W = 22;
   localparam int MUL_B_W = 19;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   typedef enum logic [1:0] {
      ACT_WRITE      = 2'd0,
      ACT_START      = 2'd1,
      ACT_BACKGROUND = 2'd2,
      ACT_TICK       = 2'd3
   } action_type;

   typedef logic        [15:0] word_type;
   typedef logic signed [15:0] sample_type;
   typedef logic        [8:0]  gain_type;
   typedef logic        [3:0]  count_type;

endpackage

// ===== design/pvm_if.sv =====
// ----------------------------------------------------------------------------
// pvm_if: request and response channels of the PCM voice mixer
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pvm_req_if import pvm_pkg::*; ();
   logic       valid;
   logic       ready;
   action_type action;
   word_type   address;
   sample_type sample_data;
   word_type   length_frames;
   logic       loops;
   word_type   loop_frame;
   logic       stereo;
   gain_type   volume;

   modport source (
      output valid, action, address, sample_data, length_frames, loops,
             loop_frame, stereo, volume,
      input  ready
   );
   modport sink (
      input  valid, action, address, sample_data, length_frames, loops,
             loop_frame, stereo, volume,
      output ready
   );
endinterface

interface pvm_rsp_if import pvm_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type left_out;
   sample_type right_out;
   count_type  active_voices;
   logic       accepted;

   modport source (
      output valid, left_out, right_out, active_voices, accepted,
      input  ready
   );
   modport sink (
      input  valid, left_out, right_out, active_voices, accepted,
      output ready
   );
endinterface

// ===== design/pvm_ram.sv =====
// ----------------------------------------------------------------------------
// pvm_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module pvm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/pcm_voice_mixer.sv =====
// ----------------------------------------------------------------------------
// pcm_voice_mixer: multi-voice 16-bit PCM mixer with its own sample memory
// Effect voices plus one background voice mixed into stereo frames.
// ----------------------------------------------------------------------------
// Usage. Each request beat on req_chan carries one action: write a sample
// word, start an effect voice in the lowest free slot, set or clear the
// background voice, or tick one stereo frame. Every request gives exactly one
// response beat on rsp_chan with the mixed frame (zero unless a tick), the
// number of active voices and the accepted flag of a start.
// Sequence. A start or a background action passes EXEC and DONE on its way
// from the request beat to the response. A sample write also passes MODQ,
// MODR and MODF, since its address is reduced modulo the memory depth by the
// shared multiplier. A tick visits each voice in turn; an idle voice takes
// only the VOICE step, and each word of a mono or stereo voice (two words for
// stereo) takes a setup step, two multiplier passes and a correction step for
// the address reduction, which also issues the registered sample memory read,
// a third multiplier pass for the gain and an accumulate step.
// Only one request is in work at a time; req_chan.ready is high when the
// sequencer is idle, also while a finished response still waits.
// Reset (synchronous) frees every voice and empties the response register;
// the sample memory is not cleared and must be written before it is played.
// When the receiver stalls, the response holds and the next request waits in DONE.
// ----------------------------------------------------------------------------
module pcm_voice_mixer import pvm_pkg::*; #(
   parameter int EFFECT_VOICES = EFFECT_VOICES_DEF,
   parameter int SAMPLE_WORDS  = SAMPLE_WORDS_DEF
) (
   input  logic   clock,
   input  logic   reset,
   pvm_req_if.sink   req_chan,
   pvm_rsp_if.source rsp_chan
);

   localparam int NV     = EFFECT_VOICES + 1;
   localparam int VW     = $clog2(NV);
   localparam int CW     = $clog2(NV + 1);
   localparam int RAM_AW = $clog2(SAMPLE_WORDS);
   // Reciprocal of the depth; the quotient estimate is low by at most one.
   localparam int RECIP  = (1 << RECIP_SHIFT) / SAMPLE_WORDS;

   localparam logic [VW-1:0]      BG_IDX   = VW'(EFFECT_VOICES);
   localparam logic [MUL_A_W-1:0] DEPTH_L  = MUL_A_W'(SAMPLE_WORDS);
   localparam logic [MUL_B_W-1:0] RECIP_L  = MUL_B_W'(RECIP);

   // The sequencer. Every word of a tick walks VOICE, MODQ, MODR, MODF, READ
   // and SCALE; a write walks MODQ, MODR and MODF only.
   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_EXEC  = 9'b000000010,
      S_VOICE = 9'b000000100,
      S_MODQ  = 9'b000001000,
      S_MODR  = 9'b000010000,
      S_MODF  = 9'b000100000,
      S_READ  = 9'b001000000,
      S_SCALE = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // The request being worked on.
   action_type it_action_ff, it_action_in;
   word_type   it_address_ff, it_address_in;
   sample_type it_sample_ff, it_sample_in;
   word_type   it_length_ff, it_length_in;
   logic       it_loops_ff, it_loops_in;
   word_type   it_loop_frame_ff, it_loop_frame_in;
   logic       it_stereo_ff, it_stereo_in;
   gain_type   it_volume_ff, it_volume_in;

   // Voice table, one entry per slot; the background voice is the last one.
   logic     voice_active_ff [NV];
   logic     voice_active_in [NV];
   word_type voice_base_ff [NV];
   word_type voice_base_in [NV];
   word_type voice_length_ff [NV];
   word_type voice_length_in [NV];
   logic     voice_loop_on_ff [NV];
   logic     voice_loop_on_in [NV];
   word_type voice_loop_start_ff [NV];
   word_type voice_loop_start_in [NV];
   logic     voice_is_stereo_ff [NV];
   logic     voice_is_stereo_in [NV];
   gain_type voice_gain_ff [NV];
   gain_type voice_gain_in [NV];
   word_type voice_position_ff [NV];
   word_type voice_position_in [NV];

   // Datapath registers.
   logic [VW-1:0]          vidx_ff, vidx_in;
   logic                   chan_ff, chan_in;
   logic [FULL_ADDR_W-1:0] addr_ff, addr_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   word_type               left_ff, left_in;
   word_type               right_ff, right_in;
   logic                   acc_ff, acc_in;

   // Response register.
   logic       rsp_valid_ff, rsp_valid_in;
   sample_type out_left_ff, out_left_in;
   sample_type out_right_ff, out_right_in;
   count_type  out_count_ff, out_count_in;
   logic       out_acc_ff, out_acc_in;

   // Shared multiplier and its operands.
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  product;

   // Address reduction and memory port.
   logic [MUL_A_W-1:0] mod_diff;
   logic [MUL_A_W-1:0] mod_rem;
   logic [RAM_AW-1:0]  ram_addr;
   logic               ram_wr_en;
   logic               ram_rd_en;
   word_type           ram_rd_data;

   // Scaling of one word.
   logic signed [26:0] scale_prod;
   logic signed [26:0] scale_biased;
   logic signed [26:0] scale_shifted;
   word_type           scaled;

   // Slot search and voice count.
   logic          slot_found;
   logic [VW-1:0] slot_idx;
   logic [CW-1:0] active_count;
   logic [16:0]   next_pos;
   logic          req_fire;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.left_out      = out_left_ff;
   assign rsp_chan.right_out     = out_right_ff;
   assign rsp_chan.active_voices = out_count_ff;
   assign rsp_chan.accepted      = out_acc_ff;

   // Lowest free effect slot.
   always_comb begin
      slot_found = 1'b0;
      slot_idx   = '0;
      for (int k = EFFECT_VOICES - 1; k >= 0; k--) begin
         if (!voice_active_ff[k]) begin
            slot_found = 1'b1;
            slot_idx   = VW'(k);
         end
      end
   end

   always_comb begin
      active_count = '0;
      for (int k = 0; k < NV; k++) begin
         active_count = active_count + CW'(voice_active_ff[k]);
      end
   end

   // Operand selection of the shared multiplier: quotient estimate, quotient
   // times depth, and sample times gain.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MODQ: begin
            mul_a = signed'(MUL_A_W'(addr_ff));
            mul_b = signed'(RECIP_L);
         end
         S_MODR: begin
            mul_a = signed'(DEPTH_L);
            mul_b = signed'(MUL_B_W'(prod_ff[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT]));
         end
         S_READ: begin
            mul_a = MUL_A_W'(signed'(ram_rd_data));
            mul_b = signed'(MUL_B_W'(voice_gain_ff[vidx_ff]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product = mul_a * mul_b;

   // The estimated quotient is exact or one low, so one correction suffices.
   assign mod_diff  = MUL_A_W'(addr_ff) - prod_ff[MUL_A_W-1:0];
   assign mod_rem   = (mod_diff >= DEPTH_L) ? (mod_diff - DEPTH_L) : mod_diff;
   assign ram_addr  = mod_rem[RAM_AW-1:0];
   assign ram_wr_en = (state_ff == S_MODF) && (it_action_ff == ACT_WRITE);
   assign ram_rd_en = (state_ff == S_MODF) && (it_action_ff == ACT_TICK);

   pvm_ram #(
      .WIDTH (16),
      .DEPTH (SAMPLE_WORDS)
   ) u_sample_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (word_type'(it_sample_ff)),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   // Division by 256 or 512 that truncates toward zero, then wrap to 16 bits.
   assign scale_prod    = prod_ff[26:0];
   assign scale_biased  = scale_prod + (scale_prod[26]
                          ? (voice_is_stereo_ff[vidx_ff] ? 27'sd255 : 27'sd511)
                          : 27'sd0);
   assign scale_shifted = voice_is_stereo_ff[vidx_ff] ? (scale_biased >>> 8)
                                                      : (scale_biased >>> 9);
   assign scaled        = scale_shifted[15:0];

   assign next_pos = {1'b0, voice_position_ff[vidx_ff]} + 17'd1;

   always_comb begin
      state_in         = state_ff;
      it_action_in     = it_action_ff;
      it_address_in    = it_address_ff;
      it_sample_in     = it_sample_ff;
      it_length_in     = it_length_ff;
      it_loops_in      = it_loops_ff;
      it_loop_frame_in = it_loop_frame_ff;
      it_stereo_in     = it_stereo_ff;
      it_volume_in     = it_volume_ff;
      voice_active_in     = voice_active_ff;
      voice_base_in       = voice_base_ff;
      voice_length_in     = voice_length_ff;
      voice_loop_on_in    = voice_loop_on_ff;
      voice_loop_start_in = voice_loop_start_ff;
      voice_is_stereo_in  = voice_is_stereo_ff;
      voice_gain_in       = voice_gain_ff;
      voice_position_in   = voice_position_ff;
      vidx_in      = vidx_ff;
      chan_in      = chan_ff;
      addr_in      = addr_ff;
      prod_in      = prod_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      out_left_in  = out_left_ff;
      out_right_in = out_right_ff;
      out_count_in = out_count_ff;
      out_acc_in   = out_acc_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               it_action_in     = req_chan.action;
               it_address_in    = req_chan.address;
               it_sample_in     = req_chan.sample_data;
               it_length_in     = req_chan.length_frames;
               it_loops_in      = req_chan.loops;
               it_loop_frame_in = req_chan.loop_frame;
               it_stereo_in     = req_chan.stereo;
               it_volume_in     = req_chan.volume;
               left_in  = '0;
               right_in = '0;
               acc_in   = 1'b1;
               vidx_in  = '0;
               chan_in  = 1'b0;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            unique case (it_action_ff)
               ACT_WRITE: begin
                  addr_in  = FULL_ADDR_W'(it_address_ff);
                  state_in = S_MODQ;
               end
               ACT_START: begin
                  if (slot_found) begin
                     voice_active_in[slot_idx]     = 1'b1;
                     voice_base_in[slot_idx]       = it_address_ff;
                     voice_length_in[slot_idx]     = it_length_ff;
                     voice_loop_on_in[slot_idx]    = it_loops_ff;
                     voice_loop_start_in[slot_idx] = it_loop_frame_ff;
                     voice_is_stereo_in[slot_idx]  = it_stereo_ff;
                     voice_gain_in[slot_idx]       = it_volume_ff;
                     voice_position_in[slot_idx]   = '0;
                  end else begin
                     acc_in = 1'b0;
                  end
                  state_in = S_DONE;
               end
               ACT_BACKGROUND: begin
                  if (it_length_ff == '0) begin
                     // A zero length clears the background and sets its gain to the new volume.
                     voice_active_in[BG_IDX] = 1'b0;
                     voice_gain_in[BG_IDX]   = it_volume_ff;
                  end else if (voice_active_ff[BG_IDX] &&
                               voice_base_ff[BG_IDX] == it_address_ff) begin
                     // Same sound already playing: only the volume changes.
                     voice_gain_in[BG_IDX] = it_volume_ff;
                  end else begin
                     voice_active_in[BG_IDX]     = 1'b1;
                     voice_base_in[BG_IDX]       = it_address_ff;
                     voice_length_in[BG_IDX]     = it_length_ff;
                     voice_loop_on_in[BG_IDX]    = it_loops_ff;
                     voice_loop_start_in[BG_IDX] = it_loop_frame_ff;
                     voice_is_stereo_in[BG_IDX]  = it_stereo_ff;
                     voice_gain_in[BG_IDX]       = it_volume_ff;
                     voice_position_in[BG_IDX]   = '0;
                  end
                  state_in = S_DONE;
               end
               ACT_TICK: begin
                  state_in = S_VOICE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         S_VOICE: begin
            if (!voice_active_ff[vidx_ff]) begin
               if (vidx_ff == BG_IDX) begin
                  state_in = S_DONE;
               end else begin
                  vidx_in = vidx_ff + VW'(1);
               end
            end else begin
               // Stereo frames hold two words, left first.
               addr_in = FULL_ADDR_W'(voice_base_ff[vidx_ff]) +
                         (voice_is_stereo_ff[vidx_ff]
                          ? FULL_ADDR_W'({voice_position_ff[vidx_ff], chan_ff})
                          : FULL_ADDR_W'(voice_position_ff[vidx_ff]));
               state_in = S_MODQ;
            end
         end

         S_MODQ: begin
            prod_in  = product;
            state_in = S_MODR;
         end

         S_MODR: begin
            prod_in  = product;
            state_in = S_MODF;
         end

         S_MODF: begin
            state_in = (it_action_ff == ACT_WRITE) ? S_DONE : S_READ;
         end

         S_READ: begin
            prod_in  = product;
            state_in = S_SCALE;
         end

         S_SCALE: begin
            if (!voice_is_stereo_ff[vidx_ff] || !chan_ff) begin
               left_in = left_ff + scaled;
            end
            if (!voice_is_stereo_ff[vidx_ff] || chan_ff) begin
               right_in = right_ff + scaled;
            end
            if (voice_is_stereo_ff[vidx_ff] && !chan_ff) begin
               chan_in  = 1'b1;
               state_in = S_VOICE;
            end else begin
               // The frame just played still counts; then loop or end.
               if (next_pos >= {1'b0, voice_length_ff[vidx_ff]}) begin
                  if (voice_loop_on_ff[vidx_ff]) begin
                     voice_position_in[vidx_ff] = voice_loop_start_ff[vidx_ff];
                  end else begin
                     voice_active_in[vidx_ff] = 1'b0;
                  end
               end else begin
                  voice_position_in[vidx_ff] = next_pos[15:0];
               end
               chan_in = 1'b0;
               if (vidx_ff == BG_IDX) begin
                  state_in = S_DONE;
               end else begin
                  vidx_in  = vidx_ff + VW'(1);
                  state_in = S_VOICE;
               end
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               out_left_in  = sample_type'(left_ff);
               out_right_in = sample_type'(right_ff);
               out_count_in = 4'(active_count);
               out_acc_in   = acc_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NV; k++) begin
            voice_active_ff[k] <= 1'b0;
         end
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         voice_active_ff <= voice_active_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      it_action_ff        <= it_action_in;
      it_address_ff       <= it_address_in;
      it_sample_ff        <= it_sample_in;
      it_length_ff        <= it_length_in;
      it_loops_ff         <= it_loops_in;
      it_loop_frame_ff    <= it_loop_frame_in;
      it_stereo_ff        <= it_stereo_in;
      it_volume_ff        <= it_volume_in;
      voice_base_ff       <= voice_base_in;
      voice_length_ff     <= voice_length_in;
      voice_loop_on_ff    <= voice_loop_on_in;
      voice_loop_start_ff <= voice_loop_start_in;
      voice_is_stereo_ff  <= voice_is_stereo_in;
      voice_gain_ff       <= voice_gain_in;
      voice_position_ff   <= voice_position_in;
      vidx_ff             <= vidx_in;
      chan_ff             <= chan_in;
      addr_ff             <= addr_in;
      prod_ff             <= prod_in;
      left_ff             <= left_in;
      right_ff            <= right_in;
      acc_ff              <= acc_in;
      out_left_ff         <= out_left_in;
      out_right_ff        <= out_right_in;
      out_count_ff        <= out_count_in;
      out_acc_ff          <= out_acc_in;
   end

endmodule
